### design/dct_pkg.sv
// shared types, register indexes and reset values for the defrost cycle timer
package dct_pkg;

    localparam int unsigned TimerW = 16;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [TimerW-1:0] CoolingReset = 16'd28800;
    localparam logic [TimerW-1:0] ActiveReset  = 16'd2400;
    localparam logic [TimerW-1:0] PassiveReset = 16'd120;
    localparam logic [ByteW-1:0]  SaveIntReset = 8'd57;
    localparam logic [TimerW-1:0] TestReset    = 16'd5;
    localparam logic [ByteW-1:0]  QualReset    = 8'd255;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_COOLING = 3'd0,
        CFG_ACTIVE  = 3'd1,
        CFG_PASSIVE = 3'd2,
        CFG_SAVE_INT = 3'd3,
        CFG_TEST    = 3'd4,
        CFG_QUALIFY = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_TEST    = 2'd1,
        ACT_THERM   = 2'd2,
        ACT_RESTORE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_COOL    = 2'd0,
        PH_ACTIVE  = 2'd1,
        PH_PASSIVE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TimerW-1:0] cooling_seconds;
        logic [TimerW-1:0] active_defrost_seconds;
        logic [TimerW-1:0] passive_defrost_seconds;
        logic [ByteW-1:0]  save_interval;
        logic [TimerW-1:0] test_seconds;
        logic [ByteW-1:0]  qualify_count;
    } cfg_t;

    typedef struct packed {
        logic [TimerW-1:0] saved_second;
        logic [TimerW-1:0] saved_first;
        logic              thermostat_high;
        action_t           action;
    } item_t;

    typedef struct packed {
        logic [TimerW-1:0] save_value;
        logic              save_request;
        logic [TimerW-1:0] remaining;
        logic              heater_on;
        logic [1:0]        phase;
    } result_t;

endpackage

### design/dct_cfg_regs.sv
// configuration register file written through the plain write port
module dct_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dct_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dct_pkg::CfgDataW-1:0]  cfg_wdata,
    output dct_pkg::cfg_t                 cfg
);

    dct_pkg::cfg_t cfg_reg;
    dct_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (dct_pkg::cfg_idx_t'(cfg_index))
                dct_pkg::CFG_COOLING:  cfg_next.cooling_seconds = cfg_wdata;
                dct_pkg::CFG_ACTIVE:   cfg_next.active_defrost_seconds = cfg_wdata;
                dct_pkg::CFG_PASSIVE:  cfg_next.passive_defrost_seconds = cfg_wdata;
                dct_pkg::CFG_SAVE_INT: cfg_next.save_interval = cfg_wdata[dct_pkg::ByteW-1:0];
                dct_pkg::CFG_TEST:     cfg_next.test_seconds = cfg_wdata;
                dct_pkg::CFG_QUALIFY:  cfg_next.qualify_count = cfg_wdata[dct_pkg::ByteW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cooling_seconds         <= dct_pkg::CoolingReset;
            cfg_reg.active_defrost_seconds  <= dct_pkg::ActiveReset;
            cfg_reg.passive_defrost_seconds <= dct_pkg::PassiveReset;
            cfg_reg.save_interval           <= dct_pkg::SaveIntReset;
            cfg_reg.test_seconds            <= dct_pkg::TestReset;
            cfg_reg.qualify_count           <= dct_pkg::QualReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/dct_seq.sv
// phase sequencer state and the single-pass update for one item
module dct_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  dct_pkg::item_t    item,
    input  dct_pkg::cfg_t     cfg,
    output dct_pkg::result_t  result
);

    dct_pkg::phase_t                 phase_reg, phase_next, phase_mid;
    logic [dct_pkg::TimerW-1:0]      timer_reg, timer_next, timer_mid, restore_val;
    logic [dct_pkg::ByteW-1:0]       qual_reg, qual_next;
    logic [dct_pkg::ByteW-1:0]       cd_reg, cd_next, cd_mid;
    logic                            heater_reg, heater_next;
    logic                            enter_req;
    logic                            periodic;
    logic [dct_pkg::ByteW:0]         twice_int;

    assign twice_int = {cfg.save_interval, 1'b0};

    // next state from the action
    always_comb begin
        phase_mid   = phase_reg;
        timer_mid   = timer_reg;
        qual_next   = qual_reg;
        cd_mid      = cd_reg;
        heater_next = heater_reg;
        enter_req   = 1'b0;
        restore_val = timer_reg;
        case (item.action)
            dct_pkg::ACT_TICK: begin
                if (cd_reg != '0) cd_mid = cd_reg - 1'b1;
                if (timer_reg != '0) begin
                    timer_mid = timer_reg - 1'b1;
                end else begin
                    case (phase_reg)
                        dct_pkg::PH_COOL: begin
                            phase_mid   = dct_pkg::PH_ACTIVE;
                            timer_mid   = cfg.active_defrost_seconds;
                            qual_next   = cfg.qualify_count;
                            heater_next = 1'b1;
                            enter_req   = 1'b1;
                        end
                        dct_pkg::PH_ACTIVE: begin
                            phase_mid = dct_pkg::PH_PASSIVE;
                            timer_mid = cfg.passive_defrost_seconds;
                        end
                        default: begin
                            phase_mid   = dct_pkg::PH_COOL;
                            timer_mid   = cfg.cooling_seconds;
                            heater_next = 1'b0;
                        end
                    endcase
                end
            end
            dct_pkg::ACT_TEST: begin
                timer_mid = cfg.test_seconds;
            end
            dct_pkg::ACT_THERM: begin
                if (phase_reg == dct_pkg::PH_ACTIVE && item.thermostat_high) begin
                    if (qual_reg != '0) begin
                        qual_next = qual_reg - 1'b1;
                    end else begin
                        phase_mid = dct_pkg::PH_PASSIVE;
                        timer_mid = cfg.passive_defrost_seconds;
                    end
                end
            end
            default: begin
                if (item.saved_first == item.saved_second) restore_val = item.saved_first;
                if (restore_val > cfg.cooling_seconds) restore_val = cfg.cooling_seconds;
                if (restore_val < {{(dct_pkg::TimerW-dct_pkg::ByteW-1){1'b0}}, twice_int})
                    restore_val = cfg.cooling_seconds;
                timer_mid = restore_val;
            end
        endcase
        phase_next = phase_mid;
        timer_next = timer_mid;
    end

    // save request and result fields
    always_comb begin
        periodic = !enter_req && phase_mid == dct_pkg::PH_COOL && cd_mid == '0;
        cd_next  = periodic ? cfg.save_interval : cd_mid;
        result.phase        = phase_mid;
        result.heater_on    = heater_next;
        result.remaining    = timer_mid;
        result.save_request = enter_req || periodic;
        if (enter_req)     result.save_value = cfg.cooling_seconds;
        else if (periodic) result.save_value = timer_mid;
        else               result.save_value = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= dct_pkg::PH_COOL;
            timer_reg  <= dct_pkg::CoolingReset;
            qual_reg   <= '0;
            cd_reg     <= '0;
            heater_reg <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            qual_reg   <= qual_next;
            cd_reg     <= cd_next;
            heater_reg <= heater_next;
        end
    end

endmodule

### design/defrost_cycle_timer.sv
// top level of the defrost cycle timer: input register, sequencer, result register
//
// usage: one input transfer per event (tick, test press, thermostat change or
// restore) on the s_ channel, with the action code in s_tuser. each input
// transfer yields exactly one result transfer on the m_ channel carrying the
// phase, heater drive, timer value and an optional save request.
// an item is held in the input register, updated through the combinational
// sequencer logic and lands in the result register, which drives m_tvalid.
// throughput: one item per cycle while m_tready is high; the sequencer state
// update is combinational compare, decrement and reload logic.
// when m_tready is low the result register holds its transfer and the input
// register keeps one more item; s_tready drops only when both are full.
// configuration is written through cfg_wr_en / cfg_index / cfg_wdata, by the
// user only while idle, which the block does not enforce; unknown indexes
// are ignored. reset (aresetn low, synchronous) empties both registers, puts
// the sequencer in cooling with the timer at 28800 and restores the cfg registers.
module defrost_cycle_timer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // thermostat_high [0], saved_first [16:1], saved_second [32:17]
    input  logic [39:0]                   s_tdata,
    // action [1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // phase [1:0], heater_on [2], remaining [18:3], save_request [19],
    // save_value [35:20]
    output logic [39:0]                   m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [dct_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dct_pkg::CfgDataW-1:0]  cfg_wdata
);

    dct_pkg::cfg_t    cfg;
    dct_pkg::item_t   item_reg;
    dct_pkg::result_t result, result_reg;
    logic             in_valid_reg, out_valid_reg;
    logic             out_free, advance, s_take;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    dct_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dct_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_take) in_valid_reg <= 1'b1;
            else if (advance) in_valid_reg <= 1'b0;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg.action          <= dct_pkg::action_t'(s_tuser);
            item_reg.thermostat_high <= s_tdata[0];
            item_reg.saved_first     <= s_tdata[16:1];
            item_reg.saved_second    <= s_tdata[32:17];
        end
        if (advance) result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, result_reg};

endmodule

### bench/dct_checker.sv
// checker for the defrost cycle timer: watches both channels, predicts each status and compares
module dct_checker
    import dct_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [39:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [39:0]         m_tdata,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output int                  mismatches,
    output int                  waiting,
    output int                  statuses_checked,
    output int                  saves_seen,
    output int                  phase_changes,
    output int                  early_ends
);

    result_t           status_q[$];
    cfg_t              cfg;
    phase_t            ph;
    logic [TimerW-1:0] timer;
    logic [ByteW-1:0]  qual;
    logic [ByteW-1:0]  save_cnt;
    logic              heater;

    initial begin
        mismatches       = 0;
        waiting          = 0;
        statuses_checked = 0;
        saves_seen       = 0;
        phase_changes    = 0;
        early_ends       = 0;
    end

    function automatic result_t advance_defrost(item_t it);
        result_t           r;
        logic              req;
        logic [TimerW-1:0] sval;
        req  = 1'b0;
        sval = '0;
        case (it.action)
            ACT_TICK: begin
                if (save_cnt != 0) save_cnt = save_cnt - 1'b1;
                if (timer != 0) begin
                    timer = timer - 1'b1;
                end else if (ph == PH_COOL) begin
                    ph     = PH_ACTIVE;
                    timer  = cfg.active_defrost_seconds;
                    qual   = cfg.qualify_count;
                    heater = 1'b1;
                    req    = 1'b1;
                    sval   = cfg.cooling_seconds;
                    phase_changes++;
                end else if (ph == PH_ACTIVE) begin
                    ph    = PH_PASSIVE;
                    timer = cfg.passive_defrost_seconds;
                    phase_changes++;
                end else begin
                    ph     = PH_COOL;
                    timer  = cfg.cooling_seconds;
                    heater = 1'b0;
                    phase_changes++;
                end
            end
            ACT_TEST: begin
                timer = cfg.test_seconds;
            end
            ACT_THERM: begin
                if (ph == PH_ACTIVE && it.thermostat_high) begin
                    if (qual != 0) begin
                        qual = qual - 1'b1;
                    end else begin
                        ph    = PH_PASSIVE;
                        timer = cfg.passive_defrost_seconds;
                        early_ends++;
                        phase_changes++;
                    end
                end
            end
            default: begin
                if (it.saved_first == it.saved_second) timer = it.saved_first;
                if (timer > cfg.cooling_seconds) timer = cfg.cooling_seconds;
                if ({1'b0, timer} < {cfg.save_interval, 1'b0}) timer = cfg.cooling_seconds;
            end
        endcase
        // periodic save while cooling
        if (!req && ph == PH_COOL && save_cnt == 0) begin
            req      = 1'b1;
            sval     = timer;
            save_cnt = cfg.save_interval;
        end
        r.phase        = ph;
        r.heater_on    = heater;
        r.remaining    = timer;
        r.save_request = req;
        r.save_value   = sval;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        item_t   it;
        result_t want;
        result_t got;
        if (!aresetn) begin
            status_q.delete();
            cfg      = '{CoolingReset, ActiveReset, PassiveReset, SaveIntReset, TestReset,
                         QualReset};
            ph       = PH_COOL;
            timer    = CoolingReset;
            qual     = '0;
            save_cnt = '0;
            heater   = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[35:0]);
                if (status_q.size() == 0) begin
                    $error("status transfer with nothing expected: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    check_field("phase", want.phase, got.phase);
                    check_field("heater_on", want.heater_on, got.heater_on);
                    check_field("remaining", want.remaining, got.remaining);
                    check_field("save_request", want.save_request, got.save_request);
                    check_field("save_value", want.save_value, got.save_value);
                    statuses_checked++;
                    if (got.save_request) saves_seen++;
                end
            end
            if (s_tvalid && s_tready) begin
                it.action          = action_t'(s_tuser);
                it.thermostat_high = s_tdata[0];
                it.saved_first     = s_tdata[16:1];
                it.saved_second    = s_tdata[32:17];
                status_q.push_back(advance_defrost(it));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COOLING:  cfg.cooling_seconds = cfg_wdata;
                    CFG_ACTIVE:   cfg.active_defrost_seconds = cfg_wdata;
                    CFG_PASSIVE:  cfg.passive_defrost_seconds = cfg_wdata;
                    CFG_SAVE_INT: cfg.save_interval = cfg_wdata[ByteW-1:0];
                    CFG_TEST:     cfg.test_seconds = cfg_wdata;
                    CFG_QUALIFY:  cfg.qualify_count = cfg_wdata[ByteW-1:0];
                    default: ;
                endcase
            end
        end
        waiting <= status_q.size();
    end

endmodule

### bench/tb_top.sv
// testbench top for the defrost cycle timer: clock, reset, stimulus, receiver and verdict
module tb_top;
    import dct_pkg::*;

    localparam int unsigned CycleLimit  = 500000;
    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned DrainCycles = 6;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [39:0]         m_tdata;
    logic                cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    int mismatches;
    int waiting;
    int statuses_checked;
    int saves_seen;
    int phase_changes;
    int early_ends;

    int unsigned cycle_cnt     = 0;
    int unsigned events_sent   = 0;
    int unsigned settings_used = 1;
    bit          no_idle       = 1'b0;
    cfg_t        cur;

    always #4 aclk = ~aclk;

    defrost_cycle_timer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dct_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .waiting          (waiting),
        .statuses_checked (statuses_checked),
        .saves_seen       (saves_seen),
        .phase_changes    (phase_changes),
        .early_ends       (early_ends)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_event(action_t act, logic therm, logic [TimerW-1:0] first,
                              logic [TimerW-1:0] second);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, second, first, therm};
        do @(posedge aclk); while (!s_tready);
        events_sent++;
    endtask

    task automatic send_random_event();
        int unsigned       r;
        int unsigned       top;
        action_t           act;
        logic              therm;
        logic [TimerW-1:0] first;
        logic [TimerW-1:0] second;
        r      = $urandom_range(0, 99);
        therm  = ($urandom_range(0, 3) != 0);
        first  = 16'($urandom);
        second = 16'($urandom);
        if (r < 60) begin
            act = ACT_TICK;
        end else if (r < 68) begin
            act = ACT_TEST;
        end else if (r < 88) begin
            act = ACT_THERM;
        end else begin
            act = ACT_RESTORE;
            case ($urandom_range(0, 2))
                0: ;
                1: begin
                    top   = cur.cooling_seconds + 3;
                    first = 16'($urandom_range(0, top));
                end
                default: begin
                    top   = 2 * cur.save_interval + 3;
                    first = 16'($urandom_range(0, top));
                end
            endcase
            if ($urandom_range(0, 1) != 0) second = first;
        end
        send_event(act, therm, first, second);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (waiting != 0);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic run_setting(cfg_t c, int unsigned n);
        wait_drained();
        write_reg(CFG_COOLING, c.cooling_seconds);
        write_reg(CFG_ACTIVE, c.active_defrost_seconds);
        write_reg(CFG_PASSIVE, c.passive_defrost_seconds);
        write_reg(CFG_SAVE_INT, {8'd0, c.save_interval});
        write_reg(CFG_TEST, c.test_seconds);
        write_reg(CFG_QUALIFY, {8'd0, c.qualify_count});
        // writes to unused indexes must leave every register alone
        write_reg(CfgIdxSpareLo, 16'($urandom));
        write_reg(CfgIdxSpareHi, 16'($urandom));
        cfg_wr_en <= 1'b0;
        cur = c;
        settings_used++;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 150 == 0) no_idle <= ($urandom_range(0, 2) == 0);
            send_random_event();
        end
        s_tvalid <= 1'b0;
    endtask

    // receiver: random backpressure plus two long hold-offs
    initial begin
        int unsigned hold;
        int unsigned results_seen;
        results_seen = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_seen == 150 || results_seen == 1000) hold = HoldCycles;
            else hold = pick_gap();
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
        end
    end

    initial begin
        cur = '{CoolingReset, ActiveReset, PassiveReset, SaveIntReset, TestReset, QualReset};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk through all three phases at reset settings
        send_event(ACT_TICK, 1'b0, 16'd0, 16'd0);
        send_event(ACT_RESTORE, 1'b0, 16'hFFFF, 16'hFFFF);
        send_event(ACT_RESTORE, 1'b1, 16'd0, 16'd0);
        send_event(ACT_RESTORE, 1'b0, 16'd500, 16'd500);
        send_event(ACT_THERM, 1'b1, 16'hFFFF, 16'h0000);
        send_event(ACT_TEST, 1'b0, 16'h0000, 16'hFFFF);
        repeat (6) send_event(ACT_TICK, 1'b0, 16'd0, 16'd0);
        send_event(ACT_THERM, 1'b0, 16'd0, 16'd0);
        send_event(ACT_THERM, 1'b1, 16'd0, 16'd0);
        send_event(ACT_TEST, 1'b0, 16'd0, 16'd0);
        repeat (6) send_event(ACT_TICK, 1'b1, 16'd0, 16'd0);
        send_event(ACT_TEST, 1'b0, 16'd0, 16'd0);
        repeat (6) send_event(ACT_TICK, 1'b0, 16'd0, 16'd0);
        s_tvalid <= 1'b0;

        run_setting(cfg_t'{16'd20, 16'd10, 16'd5, 8'd3, 16'd0, 8'd2}, 220);
        run_setting(cfg_t'{16'd1, 16'd1, 16'd1, 8'd1, 16'd1, 8'd0}, 220);
        // zero save interval: a save on every event while cooling
        run_setting(cfg_t'{16'd30, 16'd8, 16'd4, 8'd0, 16'd2, 8'd1}, 220);
        run_setting(cfg_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 8'd255}, 100);
        repeat (4) begin
            run_setting(cfg_t'{16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)),
                               16'($urandom_range(1, 10)), 8'($urandom_range(1, 15)),
                               16'($urandom_range(0, 10)), 8'($urandom_range(0, 6))}, 220);
        end

        wait_drained();
        $display("covered %0d events over %0d register settings,", events_sent, settings_used);
        $display("%0d phase changes, %0d early defrost ends, %0d status transfers checked",
                 phase_changes, early_ends, statuses_checked);
        $display("%0d with save requests, %0d mismatches", saves_seen, mismatches);
        if (mismatches == 0 && waiting == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### defrost_cycle_timer.f
design/dct_pkg.sv
design/dct_cfg_regs.sv
design/dct_seq.sv
design/defrost_cycle_timer.sv
bench/dct_checker.sv
bench/tb_top.sv
